### design/stcp_pkg.sv
// Shared constants, codes and types for the serial time command parser.
`default_nettype none

package stcp_pkg;

    // Line buffer size in bytes; one less than this is kept per line
    localparam int LINE_BYTES = 48;
    localparam int CountW     = $clog2(LINE_BYTES);
    localparam int MaxCount   = LINE_BYTES - 1;
    localparam int PrefixLen  = 5;

    localparam int ByteW   = 8;
    localparam int ValueW  = 32;
    localparam int StatusW = 2;

    localparam logic [ValueW-1:0] ThresholdReset = 32'd1735689600;

    // Special bytes
    localparam logic [ByteW-1:0] ChCr    = 8'h0D;
    localparam logic [ByteW-1:0] ChLf    = 8'h0A;
    localparam logic [ByteW-1:0] ChNul   = 8'h00;
    localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
    localparam logic [ByteW-1:0] ChMinus = 8'h2D;
    localparam logic [ByteW-1:0] ChZero  = 8'h30;

    // Parse phases
    localparam logic [2:0] PhPrefix   = 3'd0;
    localparam logic [2:0] PhMismatch = 3'd1;
    localparam logic [2:0] PhSpace    = 3'd2;
    localparam logic [2:0] PhDigits   = 3'd3;
    localparam logic [2:0] PhStop     = 3'd4;
    localparam logic [2:0] PhEmpty    = 3'd5;

    // Result status codes
    localparam logic [StatusW-1:0] StSet     = 2'd0;
    localparam logic [StatusW-1:0] StRefused = 2'd1;
    localparam logic [StatusW-1:0] StUnknown = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [StatusW-1:0] status;
        logic [ValueW-1:0]  value;
    } t_result;

    // Command word "TIME " by position
    function automatic logic [ByteW-1:0] cmd_char(input logic [2:0] pos);
        logic [ByteW-1:0] c;
        case (pos)
            3'd0:    c = 8'h54; // T
            3'd1:    c = 8'h49; // I
            3'd2:    c = 8'h4D; // M
            3'd3:    c = 8'h45; // E
            3'd4:    c = 8'h20; // space
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    // Fold ASCII lowercase letters to uppercase
    function automatic logic [ByteW-1:0] fold_upper(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] r;
        r = b;
        if (b inside {[8'h61:8'h7A]}) begin
            r = b - 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/stcp_line_parser.sv
// Per-line parse state and the byte step that updates it.
`default_nettype none

module stcp_line_parser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic [stcp_pkg::ByteW-1:0]   i_byte,
    input  wire logic [stcp_pkg::ValueW-1:0]  i_threshold,
    output stcp_pkg::t_result                 o_result
);

    logic [stcp_pkg::CountW-1:0] r_count, n_count;
    logic [2:0]                  r_phase, n_phase;
    logic [stcp_pkg::ValueW-1:0] r_acc, n_acc;
    logic                        r_ovf, n_ovf;
    logic                        r_minus, n_minus;
    logic                        r_zero, n_zero;

    logic [stcp_pkg::ValueW+3:0] acc_next;
    logic [stcp_pkg::ValueW+3:0] acc_wide;
    logic                        is_digit;
    logic                        is_blank;
    logic                        in_prefix;
    logic [stcp_pkg::ValueW-1:0] final_val;

    // Classify the byte and form acc*10 + digit
    always_comb begin
        is_digit  = i_byte inside {[8'h30:8'h39]};
        is_blank  = i_byte inside {8'h20, 8'h09, 8'h0B, 8'h0C};
        in_prefix = r_count < stcp_pkg::CountW'(stcp_pkg::PrefixLen);
        acc_wide  = {4'b0, r_acc};
        acc_next  = (acc_wide << 3) + (acc_wide << 1)
                  + {{stcp_pkg::ValueW{1'b0}}, 4'(i_byte - stcp_pkg::ChZero)};
    end

    // Value at the end of the line
    always_comb begin
        if (r_ovf) begin
            final_val = '1;
        end else if (r_minus) begin
            final_val = '0 - r_acc;
        end else begin
            final_val = r_acc;
        end
    end

    // Advance the line state by one byte
    always_comb begin
        n_count  = r_count;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_minus  = r_minus;
        n_zero   = r_zero;
        o_result = '0;

        if (i_step && i_byte != stcp_pkg::ChCr) begin
            if (i_byte == stcp_pkg::ChLf) begin
                // End of line: report unless empty, then clear
                if (r_count != '0 && r_phase != stcp_pkg::PhEmpty) begin
                    o_result.valid = 1'b1;
                    if (r_phase == stcp_pkg::PhPrefix ||
                        r_phase == stcp_pkg::PhMismatch) begin
                        o_result.status = stcp_pkg::StUnknown;
                        o_result.value  = '0;
                    end else begin
                        o_result.value  = final_val;
                        o_result.status = (final_val > i_threshold) ?
                                          stcp_pkg::StSet : stcp_pkg::StRefused;
                    end
                end
                n_count = '0;
                n_phase = stcp_pkg::PhPrefix;
                n_acc   = '0;
                n_ovf   = 1'b0;
                n_minus = 1'b0;
                n_zero  = 1'b0;
            end else if (r_count < stcp_pkg::CountW'(stcp_pkg::MaxCount)) begin
                n_count = r_count + 1'b1;
                if (!r_zero) begin
                    if (i_byte == stcp_pkg::ChNul) begin
                        // Zero byte hides the rest of the line
                        n_zero = 1'b1;
                        if (r_count == '0) begin
                            n_phase = stcp_pkg::PhEmpty;
                        end
                    end else begin
                        case (r_phase)
                            stcp_pkg::PhPrefix: begin
                                if (in_prefix && stcp_pkg::fold_upper(i_byte) ==
                                    stcp_pkg::cmd_char(r_count[2:0])) begin
                                    if (r_count == stcp_pkg::CountW'(stcp_pkg::PrefixLen-1)) begin
                                        n_phase = stcp_pkg::PhSpace;
                                    end
                                end else begin
                                    n_phase = stcp_pkg::PhMismatch;
                                end
                            end
                            stcp_pkg::PhSpace: begin
                                if (is_blank) begin
                                    n_phase = r_phase;
                                end else if (i_byte == stcp_pkg::ChPlus) begin
                                    n_phase = stcp_pkg::PhDigits;
                                end else if (i_byte == stcp_pkg::ChMinus) begin
                                    n_minus = 1'b1;
                                    n_phase = stcp_pkg::PhDigits;
                                end else if (is_digit) begin
                                    if (acc_next[stcp_pkg::ValueW+3:stcp_pkg::ValueW] != '0) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        n_acc = acc_next[stcp_pkg::ValueW-1:0];
                                    end
                                    n_phase = stcp_pkg::PhDigits;
                                end else begin
                                    n_phase = stcp_pkg::PhStop;
                                end
                            end
                            stcp_pkg::PhDigits: begin
                                if (is_digit) begin
                                    if (r_ovf ||
                                        acc_next[stcp_pkg::ValueW+3:stcp_pkg::ValueW] != '0) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        n_acc = acc_next[stcp_pkg::ValueW-1:0];
                                    end
                                end else begin
                                    n_phase = stcp_pkg::PhStop;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // Hold the line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= stcp_pkg::PhPrefix;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_minus <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_minus <= n_minus;
            r_zero  <= n_zero;
        end
    end

endmodule

`default_nettype wire

### design/serial_time_command_parser_top.sv
// Top level of the serial time command parser: stream ports, threshold, I/O registers.
//
// Usage: received serial bytes enter one per transaction on the s_axis channel
// (tdata[7:0] = rx_byte). Carriage returns are ignored, a line feed closes the
// line. For each non-empty line one result transaction leaves on m_axis:
// tuser = status (0 clock set, 1 value refused, 2 unknown command) and
// tdata = epoch_value. Lines without a line feed produce nothing.
// The plausible threshold is written through cfg_wr_en/cfg_wr_data while
// the block is idle; a value must be strictly above it to be set.
// Path: a line feed accepted on s_axis loads the input register; the line
// parser forms its result, which is loaded into the result register once
// that register is free and then shows on m_axis.
// Throughput: one byte per cycle when the result slot is free; every byte is
// handled by one pass of the line parser between the input and result registers.
// Stall: while a result waits on m_axis_tready the input register may still
// fill, then s_axis_tready drops until the result is taken.
// Reset (synchronous, active low) clears the line state, empties both
// registers and restores the threshold to 1735689600.
`default_nettype none

module serial_time_command_parser_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [stcp_pkg::ValueW-1:0]     i_cfg_wr_data,  // plausible_threshold
    // byte stream in
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [stcp_pkg::ByteW-1:0]      s_axis_tdata,   // [7:0] rx_byte
    // result stream out
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [stcp_pkg::ValueW-1:0]          m_axis_tdata,   // [31:0] epoch_value
    output logic [stcp_pkg::StatusW-1:0]         m_axis_tuser    // [1:0] status
);

    logic [stcp_pkg::ValueW-1:0]  r_threshold;
    logic                         r_in_valid;
    logic [stcp_pkg::ByteW-1:0]   r_in_byte;
    logic                         r_out_valid;
    logic [stcp_pkg::StatusW-1:0] r_out_status;
    logic [stcp_pkg::ValueW-1:0]  r_out_value;

    logic              out_free;
    logic              step;
    stcp_pkg::t_result result;

    // Advance when the result slot is empty or being drained
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

    stcp_line_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_threshold (r_threshold),
        .o_result    (result)
    );

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= stcp_pkg::ThresholdReset;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_out_status <= result.status;
            r_out_value  <= result.value;
        end
    end

endmodule

`default_nettype wire
